### rtl/core/ntpd_pkg.sv
// ----------------------------------------------------------------------------
// ntpd_pkg
// Shared types, codes and the micro-program of the three-point slope engine.
// ----------------------------------------------------------------------------
package ntpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PC_BITS   = 4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    // Quotient kinds computed by the arithmetic engine
    typedef enum logic [1:0] {
        OP_ONE = 2'd0,   // one-sided difference
        OP_CEN = 2'd1,   // weighted central difference
        OP_EXT = 2'd2    // linear extrapolation of two slopes
    } op_t;

    typedef enum logic [2:0] {
        UOP_LDA  = 3'd0,
        UOP_MUL  = 3'd1,
        UOP_SETN = 3'd2,
        UOP_ADDN = 3'd3,
        UOP_SETD = 3'd4,
        UOP_DIV  = 3'd5
    } uop_kind_t;

    typedef enum logic [2:0] {
        FAC_DXL = 3'd0,
        FAC_DXR = 3'd1,
        FAC_DYL = 3'd2,
        FAC_DYR = 3'd3,
        FAC_DX  = 3'd4,
        FAC_YA  = 3'd5
    } fac_t;

    typedef struct packed {
        uop_kind_t kind;
        fac_t      fac;
        logic      shift;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } arith_req_t;

    typedef struct packed {
        logic       done;
        logic [1:0] status;
    } arith_rsp_t;

    function automatic uop_t ucode(op_t op, logic [PC_BITS-1:0] pc);
        uop_t u;
        u = '{UOP_DIV, FAC_DXL, 1'b0};
        case (op)
            OP_CEN: begin
                case (pc)
                    4'd0:    u = '{UOP_LDA,  FAC_DXR, 1'b0};
                    4'd1:    u = '{UOP_MUL,  FAC_DXR, 1'b0};
                    4'd2:    u = '{UOP_MUL,  FAC_DYL, 1'b0};
                    4'd3:    u = '{UOP_SETN, FAC_DXL, 1'b1};
                    4'd4:    u = '{UOP_LDA,  FAC_DXL, 1'b0};
                    4'd5:    u = '{UOP_MUL,  FAC_DXL, 1'b0};
                    4'd6:    u = '{UOP_MUL,  FAC_DYR, 1'b0};
                    4'd7:    u = '{UOP_ADDN, FAC_DXL, 1'b1};
                    4'd8:    u = '{UOP_LDA,  FAC_DXL, 1'b0};
                    4'd9:    u = '{UOP_MUL,  FAC_DXR, 1'b0};
                    4'd10:   u = '{UOP_MUL,  FAC_DX,  1'b0};
                    4'd11:   u = '{UOP_SETD, FAC_DXL, 1'b0};
                    default: u = '{UOP_DIV,  FAC_DXL, 1'b0};
                endcase
            end
            OP_EXT: begin
                case (pc)
                    4'd0:    u = '{UOP_LDA,  FAC_YA,  1'b0};
                    4'd1:    u = '{UOP_MUL,  FAC_DXL, 1'b0};
                    4'd2:    u = '{UOP_SETN, FAC_DXL, 1'b0};
                    4'd3:    u = '{UOP_LDA,  FAC_DYL, 1'b0};
                    4'd4:    u = '{UOP_MUL,  FAC_DX,  1'b0};
                    4'd5:    u = '{UOP_ADDN, FAC_DXL, 1'b0};
                    4'd6:    u = '{UOP_LDA,  FAC_DXL, 1'b0};
                    4'd7:    u = '{UOP_SETD, FAC_DXL, 1'b0};
                    default: u = '{UOP_DIV,  FAC_DXL, 1'b0};
                endcase
            end
            default: begin
                case (pc)
                    4'd0:    u = '{UOP_LDA,  FAC_DYL, 1'b0};
                    4'd1:    u = '{UOP_SETN, FAC_DXL, 1'b1};
                    4'd2:    u = '{UOP_LDA,  FAC_DXL, 1'b0};
                    4'd3:    u = '{UOP_SETD, FAC_DXL, 1'b0};
                    default: u = '{UOP_DIV,  FAC_DXL, 1'b0};
                endcase
            end
        endcase
        return u;
    endfunction

endpackage

### rtl/core/nonuniform_three_point_derivative_unit.sv
// ----------------------------------------------------------------------------
// nonuniform_three_point_derivative_unit
// Streaming first derivative of (x, y) samples on a non-uniform grid.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction
//  s_        s_x_pos, s_y_val, s_last_sample         in  (valid/ready)
//  m_        m_slope, m_status, m_last_result        out (valid/ready)
//  cfg_      cfg_we, cfg_wdata (extrapolate_ends)    in  (write only)
//
//  One sample at a time; s_ready is high only while the unit is idle.
//  Each quotient runs in one shared engine: a central difference, a
//  one-sided value or an extrapolated end value. The fourth and the last
//  sample of a sequence add up to two end computations. Results then drain
//  one beat per cycle while m_ready is high.
//  Reset is synchronous; a stalled m_ beat holds the queue.
// ----------------------------------------------------------------------------
module nonuniform_three_point_derivative_unit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_x_pos,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_val,
    input  logic                           s_last_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_slope,
    output logic [1:0]                     m_status,
    output logic                           m_last_result
);
    import ntpd_pkg::*;

    localparam int W = SAMPLE_WIDTH;

    localparam logic [2:0] CNT_ZERO  = 3'd0;
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_FILL  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_S  = 3'b001,
        PH_E1 = 3'b010,
        PH_E2 = 3'b100
    } phase_t;

    state_t              state_reg;
    phase_t              phase_reg;
    logic                ext_reg, start_reg;
    logic signed [W-1:0] x_in_reg, y_in_reg;
    logic                last_in_reg;
    logic signed [W-1:0] first_x_reg, older_x_reg, prev_x_reg, older_y_reg, prev_y_reg;
    logic signed [W-1:0] older_slope_reg, prev_slope_reg;
    logic [1:0]          older_status_reg, prev_status_reg;
    logic [2:0]          count_reg;
    logic signed [W-1:0] s_slope_reg, e1_slope_reg, e2_slope_reg;
    logic [1:0]          s_status_reg, e1_status_reg, e2_status_reg;
    logic signed [W-1:0] q_slope_reg  [4];
    logic [1:0]          q_status_reg [4];
    logic                q_last_reg   [4];
    logic [2:0]          q_cnt_reg;
    logic                m_valid_reg;
    logic signed [W-1:0] m_slope_reg;
    logic [1:0]          m_status_reg;
    logic                m_last_reg;

    arith_req_t          req;
    arith_rsp_t          rsp;
    logic signed [W-1:0] a_xa, a_ya, a_xb, a_yb, a_xc, a_yc, a_slope;

    logic signed [W-1:0] fq_slope  [4];
    logic [1:0]          fq_status [4];
    logic                fq_last   [4];
    logic [2:0]          fill_cnt;
    logic                s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // operand routing for the engine
    always_comb begin
        req.start = start_reg;
        req.op    = OP_ONE;
        a_xa = prev_x_reg;
        a_ya = prev_y_reg;
        a_xb = x_in_reg;
        a_yb = y_in_reg;
        a_xc = x_in_reg;
        a_yc = y_in_reg;
        unique case (phase_reg)
            PH_S: begin
                if (count_reg != CNT_ONE) begin
                    req.op = OP_CEN;
                    a_xa = older_x_reg;
                    a_ya = older_y_reg;
                    a_xb = prev_x_reg;
                    a_yb = prev_y_reg;
                end
            end
            PH_E1: begin
                req.op = OP_EXT;
                a_xa = older_x_reg;
                a_ya = prev_slope_reg;
                a_xb = prev_x_reg;
                a_yb = s_slope_reg;
                a_xc = first_x_reg;
            end
            default: begin
                if (count_reg >= CNT_THREE && ext_reg) begin
                    req.op = OP_EXT;
                    a_xa = older_x_reg;
                    a_ya = prev_slope_reg;
                    a_xb = prev_x_reg;
                    a_yb = s_slope_reg;
                end
            end
        endcase
    end

    ntpd_arith #(
        .W (W)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .xa      (a_xa),
        .ya      (a_ya),
        .xb      (a_xb),
        .yb      (a_yb),
        .xc      (a_xc),
        .yc      (a_yc),
        .rsp     (rsp),
        .slope   (a_slope)
    );

    // results released by this sample, in index order
    always_comb begin
        fill_cnt = 3'd0;
        for (int i = 0; i < 4; i++) begin
            fq_slope[i]  = s_slope_reg;
            fq_status[i] = s_status_reg;
            fq_last[i]   = 1'b0;
        end
        case (count_reg)
            CNT_ZERO: begin
                if (last_in_reg) begin
                    fq_slope[0]  = '0;
                    fq_status[0] = STATUS_ZERO;
                    fq_last[0]   = 1'b1;
                    fill_cnt     = 3'd1;
                end
            end
            CNT_ONE: begin
                if (last_in_reg) begin
                    fq_last[1] = 1'b1;
                    fill_cnt   = 3'd2;
                end
            end
            CNT_TWO: begin
                if (last_in_reg) begin
                    fq_slope[0]  = older_slope_reg;
                    fq_status[0] = older_status_reg;
                    fq_slope[2]  = e2_slope_reg;
                    fq_status[2] = e2_status_reg;
                    fq_last[2]   = 1'b1;
                    fill_cnt     = 3'd3;
                end
            end
            CNT_THREE: begin
                fq_slope[0]  = ext_reg ? e1_slope_reg  : older_slope_reg;
                fq_status[0] = ext_reg ? e1_status_reg : older_status_reg;
                fq_slope[1]  = prev_slope_reg;
                fq_status[1] = prev_status_reg;
                fill_cnt     = 3'd3;
                if (last_in_reg) begin
                    fq_slope[3]  = e2_slope_reg;
                    fq_status[3] = e2_status_reg;
                    fq_last[3]   = 1'b1;
                    fill_cnt     = 3'd4;
                end
            end
            default: begin
                fill_cnt = 3'd1;
                if (last_in_reg) begin
                    fq_slope[1]  = e2_slope_reg;
                    fq_status[1] = e2_status_reg;
                    fq_last[1]   = 1'b1;
                    fill_cnt     = 3'd2;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_S;
            ext_reg          <= 1'b0;
            start_reg        <= 1'b0;
            count_reg        <= CNT_ZERO;
            q_cnt_reg        <= 3'd0;
            m_valid_reg      <= 1'b0;
            first_x_reg      <= '0;
            older_x_reg      <= '0;
            prev_x_reg       <= '0;
            older_y_reg      <= '0;
            prev_y_reg       <= '0;
            older_slope_reg  <= '0;
            prev_slope_reg   <= '0;
            older_status_reg <= STATUS_OK;
            prev_status_reg  <= STATUS_OK;
        end else begin
            start_reg <= 1'b0;
            if (cfg_we) begin
                ext_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        x_in_reg    <= s_x_pos;
                        y_in_reg    <= s_y_val;
                        last_in_reg <= s_last_sample;
                        if (count_reg == CNT_ZERO) begin
                            state_reg <= ST_FILL;
                        end else begin
                            phase_reg <= PH_S;
                            start_reg <= 1'b1;
                            state_reg <= ST_CALC;
                        end
                    end
                end
                ST_CALC: begin
                    if (rsp.done) begin
                        unique case (phase_reg)
                            PH_S: begin
                                s_slope_reg  <= a_slope;
                                s_status_reg <= rsp.status;
                                if (count_reg == CNT_THREE && ext_reg) begin
                                    phase_reg <= PH_E1;
                                    start_reg <= 1'b1;
                                end else if (last_in_reg && count_reg >= CNT_TWO) begin
                                    phase_reg <= PH_E2;
                                    start_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_FILL;
                                end
                            end
                            PH_E1: begin
                                e1_slope_reg  <= a_slope;
                                e1_status_reg <= rsp.status;
                                if (last_in_reg) begin
                                    phase_reg <= PH_E2;
                                    start_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_FILL;
                                end
                            end
                            default: begin
                                e2_slope_reg  <= a_slope;
                                e2_status_reg <= rsp.status;
                                state_reg     <= ST_FILL;
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    for (int i = 0; i < 4; i++) begin
                        q_slope_reg[i]  <= fq_slope[i];
                        q_status_reg[i] <= fq_status[i];
                        q_last_reg[i]   <= fq_last[i];
                    end
                    q_cnt_reg <= fill_cnt;
                    state_reg <= (fill_cnt == 3'd0) ? ST_IDLE : ST_DRAIN;
                    // advance the sample history
                    case (count_reg)
                        CNT_ZERO: begin
                            first_x_reg <= x_in_reg;
                            prev_x_reg  <= x_in_reg;
                            prev_y_reg  <= y_in_reg;
                            count_reg   <= last_in_reg ? CNT_ZERO : CNT_ONE;
                        end
                        CNT_ONE: begin
                            if (last_in_reg) begin
                                count_reg <= CNT_ZERO;
                            end else begin
                                older_slope_reg  <= s_slope_reg;
                                older_status_reg <= s_status_reg;
                                older_x_reg      <= prev_x_reg;
                                older_y_reg      <= prev_y_reg;
                                prev_x_reg       <= x_in_reg;
                                prev_y_reg       <= y_in_reg;
                                count_reg        <= CNT_TWO;
                            end
                        end
                        CNT_TWO: begin
                            if (last_in_reg) begin
                                count_reg <= CNT_ZERO;
                            end else begin
                                prev_slope_reg  <= s_slope_reg;
                                prev_status_reg <= s_status_reg;
                                older_x_reg     <= prev_x_reg;
                                older_y_reg     <= prev_y_reg;
                                prev_x_reg      <= x_in_reg;
                                prev_y_reg      <= y_in_reg;
                                count_reg       <= CNT_THREE;
                            end
                        end
                        default: begin
                            if (last_in_reg) begin
                                count_reg <= CNT_ZERO;
                            end else begin
                                older_slope_reg  <= prev_slope_reg;
                                older_status_reg <= prev_status_reg;
                                prev_slope_reg   <= s_slope_reg;
                                prev_status_reg  <= s_status_reg;
                                older_x_reg      <= prev_x_reg;
                                older_y_reg      <= prev_y_reg;
                                prev_x_reg       <= x_in_reg;
                                prev_y_reg       <= y_in_reg;
                                count_reg        <= CNT_FOUR;
                            end
                        end
                    endcase
                end
                default: begin
                    // hand one beat to the output register when it frees up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_slope_reg  <= q_slope_reg[0];
                        m_status_reg <= q_status_reg[0];
                        m_last_reg   <= q_last_reg[0];
                        for (int i = 0; i < 3; i++) begin
                            q_slope_reg[i]  <= q_slope_reg[i+1];
                            q_status_reg[i] <= q_status_reg[i+1];
                            q_last_reg[i]   <= q_last_reg[i+1];
                        end
                        q_cnt_reg <= q_cnt_reg - 1'b1;
                        if (q_cnt_reg == 3'd1) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slope       = m_slope_reg;
    assign m_status      = m_status_reg;
    assign m_last_result = m_last_reg;

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (q_cnt_reg == 3'd0))
        else $error("input accepted with results still queued");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_CALC))
        else $error("engine result outside of calc");

    a_start_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> !rsp.done)
        else $error("engine finished in one cycle");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (q_cnt_reg != 3'd0))
        else $error("drain with empty queue");

endmodule

### rtl/core/ntpd_arith.sv
// ----------------------------------------------------------------------------
// ntpd_arith
// Micro-programmed engine: serial multiplies and a restoring divider on one
// shared wide adder; produces one saturated Q16.16 quotient per request.
// ----------------------------------------------------------------------------
module ntpd_arith #(
    parameter int W = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ntpd_pkg::arith_req_t   req,
    input  logic signed [W-1:0]    xa,
    input  logic signed [W-1:0]    ya,
    input  logic signed [W-1:0]    xb,
    input  logic signed [W-1:0]    yb,
    input  logic signed [W-1:0]    xc,
    input  logic signed [W-1:0]    yc,
    output ntpd_pkg::arith_rsp_t   rsp,
    output logic signed [W-1:0]    slope
);
    import ntpd_pkg::*;

    localparam int FW = W + 2;
    localparam int NW = 3 * FW + FRAC_BITS + 1;
    localparam int AW = NW + 2;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [6:0] {
        AS_IDLE = 7'b0000001,
        AS_EXEC = 7'b0000010,
        AS_MUL  = 7'b0000100,
        AS_NEGN = 7'b0001000,
        AS_NEGD = 7'b0010000,
        AS_DIV  = 7'b0100000,
        AS_FIN  = 7'b1000000
    } astate_t;

    astate_t               state_reg;
    logic [PC_BITS-1:0]    pc_reg;
    op_t                   op_reg;
    logic signed [FW-1:0]  dxl_reg, dxr_reg, dyl_reg, dyr_reg, dx_reg, ya_reg;
    logic [NW-1:0]         a_reg, p_reg, n_reg, d_reg, rem_reg;
    logic [FW-1:0]         m_reg;
    logic                  fneg_reg;
    logic [W-1:0]          q_reg;
    logic                  ovf_reg, neg_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic signed [W-1:0]   slope_reg;

    uop_t                  uop;
    logic signed [FW-1:0]  fac_sel;
    logic [FW-1:0]         fac_mag;
    logic [NW-1:0]         a_sh;
    logic [NW:0]           rem_sh;
    logic [AW-1:0]         opa, opb, sum;
    logic                  cin, qbit;
    logic [W-1:0]          lim_pos, lim_neg;
    logic                  over;

    assign uop = ucode(op_reg, pc_reg);

    always_comb begin
        case (uop.fac)
            FAC_DXL: fac_sel = dxl_reg;
            FAC_DXR: fac_sel = dxr_reg;
            FAC_DYL: fac_sel = dyl_reg;
            FAC_DYR: fac_sel = dyr_reg;
            FAC_DX:  fac_sel = dx_reg;
            default: fac_sel = ya_reg;
        endcase
    end

    assign fac_mag = fac_sel[FW-1] ? (FW'(0) - fac_sel) : fac_sel;
    assign a_sh    = uop.shift ? (a_reg << FRAC_BITS) : a_reg;
    assign rem_sh  = {rem_reg, n_reg[NW-1]};

    // shared adder
    always_comb begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
        unique case (state_reg)
            AS_MUL: begin
                opa = {1'b0, p_reg, 1'b0};
                if (m_reg[FW-1]) begin
                    opb = {2'b00, (fneg_reg ? ~a_reg : a_reg)};
                    cin = fneg_reg;
                end
            end
            AS_EXEC: begin
                opa = {2'b00, n_reg};
                opb = {2'b00, a_sh};
            end
            AS_NEGN: begin
                opa = {2'b00, ~n_reg};
                cin = 1'b1;
            end
            AS_NEGD: begin
                opa = {2'b00, ~d_reg};
                cin = 1'b1;
            end
            AS_DIV: begin
                opa = {1'b0, rem_sh};
                opb = ~{2'b00, d_reg};
                cin = 1'b1;
            end
            default: begin
                opa = '0;
            end
        endcase
    end

    assign sum     = opa + opb + AW'(cin);
    assign qbit    = ~sum[AW-1];
    assign lim_pos = {1'b0, {(W-1){1'b1}}};
    assign lim_neg = {1'b1, {(W-1){1'b0}}};
    assign over    = neg_reg ? (q_reg > lim_neg) : (q_reg > lim_pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                AS_IDLE: begin
                    if (req.start) begin
                        op_reg    <= req.op;
                        pc_reg    <= '0;
                        dxl_reg   <= FW'(xb) - FW'(xa);
                        dxr_reg   <= FW'(xc) - FW'(xb);
                        dyl_reg   <= FW'(yb) - FW'(ya);
                        dyr_reg   <= FW'(yc) - FW'(yb);
                        dx_reg    <= FW'(xc) - FW'(xa);
                        ya_reg    <= FW'(ya);
                        state_reg <= AS_EXEC;
                    end
                end
                AS_EXEC: begin
                    case (uop.kind)
                        UOP_LDA: begin
                            a_reg  <= {{(NW-FW){fac_sel[FW-1]}}, fac_sel};
                            pc_reg <= pc_reg + 1'b1;
                        end
                        UOP_MUL: begin
                            m_reg     <= fac_mag;
                            fneg_reg  <= fac_sel[FW-1];
                            p_reg     <= '0;
                            cnt_reg   <= CW'(FW);
                            state_reg <= AS_MUL;
                        end
                        UOP_SETN: begin
                            n_reg  <= a_sh;
                            pc_reg <= pc_reg + 1'b1;
                        end
                        UOP_ADDN: begin
                            n_reg  <= sum[NW-1:0];
                            pc_reg <= pc_reg + 1'b1;
                        end
                        UOP_SETD: begin
                            d_reg  <= a_reg;
                            pc_reg <= pc_reg + 1'b1;
                        end
                        default: begin
                            if (d_reg == '0) begin
                                slope_reg  <= '0;
                                status_reg <= STATUS_ZERO;
                                done_reg   <= 1'b1;
                                state_reg  <= AS_IDLE;
                            end else begin
                                neg_reg   <= n_reg[NW-1] ^ d_reg[NW-1];
                                rem_reg   <= '0;
                                q_reg     <= '0;
                                ovf_reg   <= 1'b0;
                                cnt_reg   <= CW'(NW);
                                state_reg <= AS_NEGN;
                            end
                        end
                    endcase
                end
                AS_MUL: begin
                    p_reg   <= sum[NW-1:0];
                    m_reg   <= m_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        a_reg     <= sum[NW-1:0];
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= AS_EXEC;
                    end
                end
                AS_NEGN: begin
                    if (n_reg[NW-1]) begin
                        n_reg <= sum[NW-1:0];
                    end
                    state_reg <= AS_NEGD;
                end
                AS_NEGD: begin
                    if (d_reg[NW-1]) begin
                        d_reg <= sum[NW-1:0];
                    end
                    state_reg <= AS_DIV;
                end
                AS_DIV: begin
                    n_reg   <= n_reg << 1;
                    rem_reg <= qbit ? sum[NW-1:0] : rem_sh[NW-1:0];
                    q_reg   <= {q_reg[W-2:0], qbit};
                    ovf_reg <= ovf_reg | q_reg[W-1];
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= AS_FIN;
                    end
                end
                default: begin
                    // clamp out-of-range quotients
                    if (ovf_reg || over) begin
                        slope_reg  <= neg_reg ? lim_neg : lim_pos;
                        status_reg <= STATUS_SAT;
                    end else begin
                        slope_reg  <= neg_reg ? ({W{1'b0}} - q_reg) : q_reg;
                        status_reg <= STATUS_OK;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= AS_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.status = status_reg;
    assign slope      = slope_reg;

endmodule

### bench/tb_nonuniform_three_point_derivative_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonuniform_three_point_derivative_unit
// Drives (x, y) sample sequences through the slope unit and compares every
// output beat against a wide-integer software estimate of the derivative.
// ----------------------------------------------------------------------------
module tb_nonuniform_three_point_derivative_unit;
    import ntpd_pkg::*;

    localparam int W = 32;
    localparam int SCALE = 65536;

    typedef struct packed {
        logic signed [W-1:0] slope;
        logic [1:0]          status;
        logic                last;
    } slope_beat_t;

    typedef struct {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic                last;
        logic                has_exp;
        slope_beat_t         exp_beat;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [W-1:0] s_x_pos = '0;
    logic signed [W-1:0] s_y_val = '0;
    logic s_last_sample = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [W-1:0] m_slope;
    logic [1:0] m_status;
    logic m_last_result;

    nonuniform_three_point_derivative_unit #(.SAMPLE_WIDTH(W)) DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_x_pos(s_x_pos),
        .s_y_val(s_y_val), .s_last_sample(s_last_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_slope(m_slope),
        .m_status(m_status), .m_last_result(m_last_result)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic signed [W-1:0] p_first_x, p_older_x, p_prev_x, p_older_y, p_prev_y;
    logic signed [W-1:0] p_older_slope, p_prev_slope;
    logic [1:0]          p_older_st, p_prev_st;
    int                  p_count;
    logic                p_extrap;

    slope_beat_t expected_slopes[$];
    int  mismatches = 0;
    bit  hold_off = 1'b0;

    // exact signed quotient, truncated, saturated
    function automatic slope_beat_t divide_sat(logic signed [191:0] num,
                                               logic signed [191:0] den);
        slope_beat_t r;
        logic signed [191:0] q;
        r.last = 1'b0;
        if (den == 0) begin
            r.slope = '0;
            r.status = STATUS_ZERO;
            return r;
        end
        q = num / den;
        if (q > 192'sd2147483647) begin
            r.slope = 32'h7fffffff; r.status = STATUS_SAT;
        end else if (q < -192'sd2147483648) begin
            r.slope = 32'h80000000; r.status = STATUS_SAT;
        end else begin
            r.slope = q[W-1:0]; r.status = STATUS_OK;
        end
        return r;
    endfunction

    function automatic slope_beat_t one_sided_slope(logic signed [W-1:0] xa,
            logic signed [W-1:0] ya, logic signed [W-1:0] xb, logic signed [W-1:0] yb);
        logic signed [191:0] n, d;
        n = (192'(signed'(yb)) - 192'(signed'(ya))) * SCALE;
        d = 192'(signed'(xb)) - 192'(signed'(xa));
        return divide_sat(n, d);
    endfunction

    function automatic slope_beat_t central_slope(logic signed [W-1:0] xa,
            logic signed [W-1:0] ya, logic signed [W-1:0] xb, logic signed [W-1:0] yb,
            logic signed [W-1:0] xc, logic signed [W-1:0] yc);
        logic signed [191:0] dxl, dxr, dyl, dyr, n, d;
        dxl = 192'(signed'(xb)) - 192'(signed'(xa));
        dxr = 192'(signed'(xc)) - 192'(signed'(xb));
        dyl = 192'(signed'(yb)) - 192'(signed'(ya));
        dyr = 192'(signed'(yc)) - 192'(signed'(yb));
        n = (dxr * dxr * dyl + dxl * dxl * dyr) * SCALE;
        d = dxl * dxr * (dxl + dxr);
        return divide_sat(n, d);
    endfunction

    function automatic slope_beat_t extrap_slope(logic signed [W-1:0] xa,
            logic signed [W-1:0] sa, logic signed [W-1:0] xb, logic signed [W-1:0] sb,
            logic signed [W-1:0] xt);
        logic signed [191:0] n, d;
        d = 192'(signed'(xb)) - 192'(signed'(xa));
        n = 192'(signed'(sa)) * d
          + (192'(signed'(sb)) - 192'(signed'(sa)))
          * (192'(signed'(xt)) - 192'(signed'(xa)));
        return divide_sat(n, d);
    endfunction

    function automatic slope_beat_t mk(logic signed [W-1:0] s, logic [1:0] st,
                                       logic l);
        slope_beat_t b;
        b.slope = s; b.status = st; b.last = l;
        return b;
    endfunction

    task automatic push(slope_beat_t b, logic l);
        b.last = l;
        expected_slopes.push_back(b);
    endtask

    // advance the derivative predictor by one accepted sample
    task automatic predict_sample(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                  logic l);
        slope_beat_t s, e;
        if (p_count == 0) begin
            p_first_x = x; p_prev_x = x; p_prev_y = y;
            if (l) push(mk('0, STATUS_ZERO, 1'b1), 1'b1);
            else p_count = 1;
            return;
        end
        if (p_count == 1) begin
            s = one_sided_slope(p_prev_x, p_prev_y, x, y);
            if (l) begin
                p_count = 0; push(s, 1'b0); push(s, 1'b1);
                return;
            end
            p_older_slope = s.slope; p_older_st = s.status;
            p_older_x = p_prev_x; p_older_y = p_prev_y; p_prev_x = x; p_prev_y = y;
            p_count = 2;
            return;
        end
        s = central_slope(p_older_x, p_older_y, p_prev_x, p_prev_y, x, y);
        if (p_count == 2) begin
            if (l) begin
                p_count = 0;
                push(mk(p_older_slope, p_older_st, 1'b0), 1'b0);
                push(s, 1'b0);
                push(one_sided_slope(p_prev_x, p_prev_y, x, y), 1'b1);
                return;
            end
            p_prev_slope = s.slope; p_prev_st = s.status;
            p_older_x = p_prev_x; p_older_y = p_prev_y; p_prev_x = x; p_prev_y = y;
            p_count = 3;
            return;
        end
        if (p_count == 3) begin
            if (p_extrap)
                e = extrap_slope(p_older_x, p_prev_slope, p_prev_x, s.slope, p_first_x);
            else e = mk(p_older_slope, p_older_st, 1'b0);
            push(e, 1'b0);
            push(mk(p_prev_slope, p_prev_st, 1'b0), 1'b0);
        end
        push(s, 1'b0);
        if (l) begin
            if (p_extrap) e = extrap_slope(p_older_x, p_prev_slope, p_prev_x, s.slope, x);
            else e = one_sided_slope(p_prev_x, p_prev_y, x, y);
            push(e, 1'b1);
            p_count = 0;
            return;
        end
        p_older_slope = p_prev_slope; p_older_st = p_prev_st;
        p_prev_slope = s.slope; p_prev_st = s.status;
        p_older_x = p_prev_x; p_older_y = p_prev_y; p_prev_x = x; p_prev_y = y;
        p_count = 4;
    endtask

    // result checker
    always @(posedge aclk) begin
        slope_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_slopes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat slope=%h status=%0d last=%0b",
                             m_slope, m_status, m_last_result);
            end else begin
                want = expected_slopes.pop_front();
                if (m_slope !== want.slope || m_status !== want.status
                        || m_last_result !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                 want.slope, want.status, want.last,
                                 m_slope, m_status, m_last_result);
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (hold_off) m_ready <= 1'b0;
            else if ((phase / 64) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // sender: offer one sample and wait for its acceptance; valid stays up
    // so that a following sample is offered without a gap
    task automatic send_sample(logic signed [W-1:0] x, logic signed [W-1:0] y,
                               logic l);
        s_valid <= 1'b1; s_x_pos <= x; s_y_val <= y; s_last_sample <= l;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_sample(x, y, l);
    endtask

    // drop valid and idle the sender
    task automatic pause_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        while (expected_slopes.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_extrap(logic v);
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        p_extrap = v;
    endtask

    // one random sequence; mostly increasing grids, some noise
    task automatic random_sequence(int len);
        logic signed [W-1:0] x, y;
        int mode;
        mode = $urandom_range(0, 9);
        x = $urandom_range(0, 1 << 20) - (1 << 19);
        for (int i = 0; i < len; i++) begin
            if (mode < 6) begin
                x = x + $urandom_range(1, 1 << 18);
                y = $urandom_range(0, 1 << 22) - (1 << 21);
            end else if (mode < 8) begin
                x = $urandom(); y = $urandom();
            end else begin
                x = x + $urandom_range(0, 3) - 1;
                y = $urandom();
            end
            send_sample(x, y, i == len - 1);
            if (i != len - 1 && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 20));
        end
    endtask

    stim_row_t rows[$];

    task automatic add_row(logic signed [W-1:0] x, logic signed [W-1:0] y, logic l);
        stim_row_t r;
        r.x = x; r.y = y; r.last = l; r.has_exp = 1'b0; r.exp_beat = '0;
        rows.push_back(r);
    endtask

    initial begin
        int sent;
        p_count = 0; p_extrap = 1'b0;
        p_first_x = '0; p_older_x = '0; p_prev_x = '0; p_older_y = '0; p_prev_y = '0;
        p_older_slope = '0; p_prev_slope = '0; p_older_st = '0; p_prev_st = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: single sample, two-sample, zero spacing, saturation,
        // three-sample, and a long sequence with extreme values
        add_row(32'sh80000000, 32'sh7fffffff, 1'b1);
        add_row(32'sd0, 32'sd0, 1'b0);          add_row(32'sd65536, 32'sd65536, 1'b1);
        add_row(32'sd5, 32'sd1, 1'b0);          add_row(32'sd5, 32'sd9, 1'b1);
        add_row(32'sd0, 32'sh80000000, 1'b0);   add_row(32'sd1, 32'sh7fffffff, 1'b1);
        add_row(32'sd0, 32'sd0, 1'b0);          add_row(32'sd65536, 32'sd131072, 1'b0);
        add_row(32'sd196608, 32'sd0, 1'b1);
        add_row(32'sh80000000, 32'sh80000000, 1'b0);
        add_row(32'sd0, 32'sh7fffffff, 1'b0);
        add_row(32'sd0, 32'sd0, 1'b0);
        add_row(32'sh7fffffff, 32'shffffffff, 1'b0);
        add_row(32'sd100, 32'sd100, 1'b1);
        rows[0].has_exp = 1'b1; rows[0].exp_beat = mk('0, STATUS_ZERO, 1'b1);
        foreach (rows[i]) begin
            if (rows[i].has_exp) expected_slopes.push_back(rows[i].exp_beat);
            send_sample(rows[i].x, rows[i].y, rows[i].last);
            if (rows[i].has_exp) void'(expected_slopes.pop_back());
        end
        drain_and_idle();

        write_extrap(1'b1);
        for (int n = 1; n <= 6; n++) random_sequence(n);
        drain_and_idle();

        // long receiver hold-off, timed on its own, while samples keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                random_sequence(8);
                s_valid <= 1'b0;
            end
        join
        drain_and_idle();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_extrap(ph[0]);
            while (sent < 35 * (ph + 1)) begin
                int len;
                len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 3)
                                                : $urandom_range(4, 9);
                random_sequence(len);
                sent += len;
                if ($urandom_range(0, 2) == 0)
                    pause_sender($urandom_range(1, 40));
            end
            drain_and_idle();
        end
        write_extrap(1'b0);

        if (mismatches == 0 && expected_slopes.size() == 0)
            $display("[nonuniform_three_point_derivative_unit] OK");
        else
            $display("[nonuniform_three_point_derivative_unit] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[nonuniform_three_point_derivative_unit] ERROR");
        $finish;
    end
endmodule
